>>> rtl/tsrt_pkg.sv
// Package for the split-region touchpad tracker: widths, field layouts,
// per-region state type, register indexes and reset constants.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tsrt_pkg;

	// Coordinate widths of the pad
	localparam int X_BITS = 11;
	localparam int Y_BITS = 10;
	localparam int ID_BITS = 7;
	localparam int OWNER_BITS = ID_BITS + 1;
	localparam int NUM_REGIONS = 3;

	// Config port widths
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;

	// Stream widths, padded to whole bytes
	localparam int IN_BITS = 2 * (1 + ID_BITS + X_BITS + Y_BITS);
	localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 1 + 3 * (X_BITS + 1) + 3 * (Y_BITS + 1);
	localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

	// Owner ids of released halves; no 7-bit touch id can match them
	localparam logic [OWNER_BITS-1:0] ID_NONE = OWNER_BITS'(255);
	localparam logic [OWNER_BITS-1:0] ID_NONE_RIGHT = OWNER_BITS'(254);

	// Register reset values
	localparam logic [X_BITS-1:0] WHOLE_OX_RST = X_BITS'(960);
	localparam logic [X_BITS-1:0] LEFT_OX_RST = X_BITS'(480);
	localparam logic [X_BITS-1:0] RIGHT_OX_RST = X_BITS'(1440);
	localparam logic [Y_BITS-1:0] ORIGIN_Y_RST = Y_BITS'(471);
	localparam logic [X_BITS-1:0] SPLIT_RST = X_BITS'(960);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_WHOLE_OX = 3'd0,
		CFG_LEFT_OX  = 3'd1,
		CFG_RIGHT_OX = 3'd2,
		CFG_ORIGIN_Y = 3'd3,
		CFG_SPLIT    = 3'd4
	} cfg_idx_e;

	typedef enum logic [1:0] {
		REG_WHOLE = 2'd0,
		REG_LEFT  = 2'd1,
		REG_RIGHT = 2'd2
	} region_e;

	typedef struct packed {
		logic [X_BITS-1:0] whole_ox;
		logic [X_BITS-1:0] left_ox;
		logic [X_BITS-1:0] right_ox;
		logic [Y_BITS-1:0] oy;
		logic [X_BITS-1:0] split;
	} cfg_t;

	// Input item; first member sits in the top bits, so f0_absent is bit 0
	typedef struct packed {
		logic [Y_BITS-1:0]  f1_y;
		logic [X_BITS-1:0]  f1_x;
		logic [ID_BITS-1:0] f1_id;
		logic               f1_absent;
		logic [Y_BITS-1:0]  f0_y;
		logic [X_BITS-1:0]  f0_x;
		logic [ID_BITS-1:0] f0_id;
		logic               f0_absent;
	} report_t;

	// Result payload carried in tdata, active in bit 0
	typedef struct packed {
		logic signed [Y_BITS:0] inc_y;
		logic signed [X_BITS:0] inc_x;
		logic signed [Y_BITS:0] disp_y;
		logic signed [X_BITS:0] disp_x;
		logic signed [Y_BITS:0] abs_y;
		logic signed [X_BITS:0] abs_x;
		logic                   active;
	} result_t;

	// Tracking state of one region
	typedef struct packed {
		logic                   active;
		logic [OWNER_BITS-1:0]  owner;
		logic [X_BITS-1:0]      start_x;
		logic [Y_BITS-1:0]      start_y;
		logic signed [X_BITS:0] abs_x;
		logic signed [Y_BITS:0] abs_y;
		logic signed [X_BITS:0] disp_x;
		logic signed [Y_BITS:0] disp_y;
		logic signed [X_BITS:0] inc_x;
		logic signed [Y_BITS:0] inc_y;
	} region_t;

	typedef region_t [NUM_REGIONS-1:0] regions_t;

endpackage

`default_nettype wire

>>> rtl/tsrt_cfg.sv
// Configuration registers of the touchpad tracker: references and split column.
// Depends on tsrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsrt_cfg
	import tsrt_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     wr_en,
	input  wire logic [CFG_IDX_BITS-1:0]  wr_index,
	input  wire logic [CFG_DATA_BITS-1:0] wr_data,
	output cfg_t                          cfg
);

	cfg_t cfg_q;

	// Register file; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.whole_ox <= WHOLE_OX_RST;
			cfg_q.left_ox  <= LEFT_OX_RST;
			cfg_q.right_ox <= RIGHT_OX_RST;
			cfg_q.oy       <= ORIGIN_Y_RST;
			cfg_q.split    <= SPLIT_RST;
		end else if (wr_en) begin
			unique case (cfg_idx_e'(wr_index))
				CFG_WHOLE_OX: cfg_q.whole_ox <= wr_data[X_BITS-1:0];
				CFG_LEFT_OX:  cfg_q.left_ox  <= wr_data[X_BITS-1:0];
				CFG_RIGHT_OX: cfg_q.right_ox <= wr_data[X_BITS-1:0];
				CFG_ORIGIN_Y: cfg_q.oy       <= wr_data[Y_BITS-1:0];
				CFG_SPLIT:    cfg_q.split    <= wr_data[X_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/tsrt_update.sv
// Next-state logic of the tracker: one report applied to the three regions.
// Purely combinational; depends on tsrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsrt_update
	import tsrt_pkg::*;
(
	input  cfg_t     cfg,
	input  report_t  rpt,
	input  regions_t cur,
	output regions_t nxt
);

	typedef region_t [1:0] pair_t;

	localparam logic signed [X_BITS+1:0] X_LIM = (X_BITS+2)'((1 << X_BITS) - 1);
	localparam logic signed [Y_BITS+1:0] Y_LIM = (Y_BITS+2)'((1 << Y_BITS) - 1);

	function automatic logic signed [X_BITS:0] sat_x(input logic signed [X_BITS+1:0] d);
		logic signed [X_BITS+1:0] v;
		v = d;
		if (d > X_LIM)
			v = X_LIM;
		else if (d < -X_LIM)
			v = -X_LIM;
		return v[X_BITS:0];
	endfunction

	function automatic logic signed [Y_BITS:0] sat_y(input logic signed [Y_BITS+1:0] d);
		logic signed [Y_BITS+1:0] v;
		v = d;
		if (d > Y_LIM)
			v = Y_LIM;
		else if (d < -Y_LIM)
			v = -Y_LIM;
		return v[Y_BITS:0];
	endfunction

	// New touch: record start point and absolute position
	function automatic region_t start_r(input region_t r, input logic [OWNER_BITS-1:0] id,
			input logic [X_BITS-1:0] x, input logic [Y_BITS-1:0] y,
			input logic [X_BITS-1:0] rx, input logic [Y_BITS-1:0] ry);
		region_t o;
		o = r;
		o.abs_x   = $signed({1'b0, x}) - $signed({1'b0, rx});
		o.abs_y   = $signed({1'b0, y}) - $signed({1'b0, ry});
		o.start_x = x;
		o.start_y = y;
		o.owner   = id;
		return o;
	endfunction

	// Held touch: increment, new absolute position, displacement
	function automatic region_t move_r(input region_t r,
			input logic [X_BITS-1:0] x, input logic [Y_BITS-1:0] y,
			input logic [X_BITS-1:0] rx, input logic [Y_BITS-1:0] ry);
		region_t o;
		logic signed [X_BITS:0] ax;
		logic signed [Y_BITS:0] ay;
		o = r;
		ax = $signed({1'b0, x}) - $signed({1'b0, rx});
		ay = $signed({1'b0, y}) - $signed({1'b0, ry});
		o.inc_x  = sat_x($signed({ax[X_BITS], ax}) - $signed({r.abs_x[X_BITS], r.abs_x}));
		o.inc_y  = sat_y($signed({ay[Y_BITS], ay}) - $signed({r.abs_y[Y_BITS], r.abs_y}));
		o.abs_x  = ax;
		o.abs_y  = ay;
		o.disp_x = $signed({1'b0, x}) - $signed({1'b0, r.start_x});
		o.disp_y = $signed({1'b0, y}) - $signed({1'b0, r.start_y});
		return o;
	endfunction

	// One finger against the two halves: claim if unknown, then move its owner
	function automatic pair_t halves(input pair_t p, input logic [ID_BITS-1:0] id,
			input logic [X_BITS-1:0] x, input logic [Y_BITS-1:0] y, input cfg_t c);
		pair_t o;
		logic [OWNER_BITS-1:0] wid;
		o = p;
		wid = {1'b0, id};
		if (wid != o[0].owner && wid != o[1].owner) begin
			if (x < c.split)
				o[0] = start_r(o[0], wid, x, y, c.left_ox, c.oy);
			else
				o[1] = start_r(o[1], wid, x, y, c.right_ox, c.oy);
		end
		if (wid == o[0].owner)
			o[0] = move_r(o[0], x, y, c.left_ox, c.oy);
		if (wid == o[1].owner)
			o[1] = move_r(o[1], x, y, c.right_ox, c.oy);
		return o;
	endfunction

	// Inactive regions report no motion
	function automatic region_t quiet(input region_t r);
		region_t o;
		o = r;
		if (!r.active) begin
			o.disp_x = '0;
			o.disp_y = '0;
			o.inc_x  = '0;
			o.inc_y  = '0;
		end
		return o;
	endfunction

	region_t whole_c;
	pair_t   half_c;

	always_comb begin
		whole_c = cur[REG_WHOLE];
		half_c  = {cur[REG_RIGHT], cur[REG_LEFT]};

		// Both fingers lifted: release the halves
		if (rpt.f0_absent && rpt.f1_absent) begin
			half_c[0].active = 1'b0;
			half_c[1].active = 1'b0;
			half_c[0].owner  = ID_NONE;
			half_c[1].owner  = ID_NONE_RIGHT;
		end

		// Activity settles before any claim; finger 1 wins on a shared id
		whole_c.active = !rpt.f0_absent;
		if (half_c[0].owner == {1'b0, rpt.f0_id})
			half_c[0].active = !rpt.f0_absent;
		if (half_c[1].owner == {1'b0, rpt.f0_id})
			half_c[1].active = !rpt.f0_absent;
		if (half_c[0].owner == {1'b0, rpt.f1_id})
			half_c[0].active = !rpt.f1_absent;
		if (half_c[1].owner == {1'b0, rpt.f1_id})
			half_c[1].active = !rpt.f1_absent;

		// Finger 0 drives the whole pad, then both fingers the halves
		if (!rpt.f0_absent) begin
			if ({1'b0, rpt.f0_id} != whole_c.owner)
				whole_c = start_r(whole_c, {1'b0, rpt.f0_id}, rpt.f0_x, rpt.f0_y,
					cfg.whole_ox, cfg.oy);
			whole_c = move_r(whole_c, rpt.f0_x, rpt.f0_y, cfg.whole_ox, cfg.oy);
			half_c = halves(half_c, rpt.f0_id, rpt.f0_x, rpt.f0_y, cfg);
		end
		if (!rpt.f1_absent)
			half_c = halves(half_c, rpt.f1_id, rpt.f1_x, rpt.f1_y, cfg);
	end

	assign nxt[REG_WHOLE] = quiet(whole_c);
	assign nxt[REG_LEFT]  = quiet(half_c[0]);
	assign nxt[REG_RIGHT] = quiet(half_c[1]);

endmodule

`default_nettype wire

>>> rtl/touchpad_split_region_tracker_top.sv
// Split-region touchpad tracker: input register, region state, result sequencer.
// Depends on tsrt_pkg, tsrt_cfg and tsrt_update.
//
// Usage:
//   s_t* carries one two-finger report per item. Each report yields three
//   result items on m_t*, in the order whole pad, left half, right half;
//   tuser holds the region number and tlast marks the right-half item.
//   cfg_* writes one register per handshake (index 0..4, others dropped);
//   cfg_ready is always high. Write only while the block is idle.
//   Order: with no results pending, a taken report waits in the input
//   register, then loads the region state and result sequencer, which show
//   its first result; the three results leave in order without gaps while
//   the receiver is ready. Flow: the single result channel moves three items
//   per report. The input register takes the next report while the current
//   results drain, and its update is applied at the edge that moves the last
//   result out.
//   A receiver stall holds the current result and the region state; the input
//   register then holds one report and drops s_tready.
//   Reset: registers take their default values, all regions read as lifted
//   (halves owned by ids 255 and 254), and no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module touchpad_split_region_tracker_top
	import tsrt_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// Report input
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// tdata, low bit up: f0_absent, f0_id, f0_x, f0_y, f1_absent, f1_id, f1_x, f1_y
	input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,
	// Result output
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// tdata, low bit up: active, abs_x, abs_y, disp_x, disp_y, inc_x, inc_y
	output logic [OUT_TDATA_BITS-1:0]      m_tdata,
	// tuser: region
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast,
	// Configuration writes
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

	cfg_t     cfg;
	report_t  rpt_s1;
	logic     valid_s1;
	regions_t state_q;
	regions_t state_nxt;
	logic     res_valid_q;
	region_e  beat_q;
	region_t  sel;
	result_t  res;
	logic     last_taken;
	logic     consume;

	// Reset state: all regions lifted, halves owned by the released ids
	function automatic regions_t state_rst();
		regions_t s;
		s = '0;
		s[REG_WHOLE].owner = ID_NONE;
		s[REG_LEFT].owner  = ID_NONE;
		s[REG_RIGHT].owner = ID_NONE_RIGHT;
		return s;
	endfunction

	assign cfg_ready = 1'b1;

	tsrt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	tsrt_update u_update (
		.cfg (cfg),
		.rpt (rpt_s1),
		.cur (state_q),
		.nxt (state_nxt)
	);

	// Report applied once the previous results are gone or leaving
	assign last_taken = res_valid_q && m_tready && (beat_q == REG_RIGHT);
	assign consume    = valid_s1 && (!res_valid_q || last_taken);
	assign s_tready   = !valid_s1 || consume;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			rpt_s1 <= report_t'(s_tdata[IN_BITS-1:0]);
	end

	// Region state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= state_rst();
		end else if (consume) begin
			state_q <= state_nxt;
		end
	end

	// Result sequencer: three items per report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			beat_q      <= REG_WHOLE;
		end else if (consume) begin
			res_valid_q <= 1'b1;
			beat_q      <= REG_WHOLE;
		end else if (res_valid_q && m_tready) begin
			unique case (beat_q)
				REG_WHOLE: beat_q <= REG_LEFT;
				REG_LEFT:  beat_q <= REG_RIGHT;
				REG_RIGHT: res_valid_q <= 1'b0;
				default:   res_valid_q <= 1'b0;
			endcase
		end
	end

	// Output selection
	always_comb begin
		case (beat_q)
			REG_LEFT:  sel = state_q[REG_LEFT];
			REG_RIGHT: sel = state_q[REG_RIGHT];
			default:   sel = state_q[REG_WHOLE];
		endcase
	end

	always_comb begin
		res.active = sel.active;
		res.abs_x  = sel.abs_x;
		res.abs_y  = sel.abs_y;
		res.disp_x = sel.disp_x;
		res.disp_y = sel.disp_y;
		res.inc_x  = sel.inc_x;
		res.inc_y  = sel.inc_y;
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = OUT_TDATA_BITS'(res);
	assign m_tuser  = beat_q;
	assign m_tlast  = (beat_q == REG_RIGHT);

endmodule

`default_nettype wire

>>> rtl/tsrt_checker.sv
// Port-level checks of the tracker's result stream, bound to the top level.
// Depends on tsrt_pkg and touchpad_split_region_tracker_top.
`timescale 1ns / 1ps
`default_nettype none

module tsrt_checker
	import tsrt_pkg::*;
(
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [OUT_TDATA_BITS-1:0] m_tdata,
	input wire logic [1:0]                m_tuser,
	input wire logic                      m_tlast
);

	localparam int MOTION_LO = 1 + (X_BITS + 1) + (Y_BITS + 1);

	// tlast only on the right-half item
	a_last_right: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == REG_RIGHT)))
		else $error("tlast does not match right-half region");

	// Items of one report follow in region order without a gap
	a_region_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && (m_tuser == $past(m_tuser) + 2'd1))
		else $error("region sequence broken");

	// Inactive region shows no displacement or increment
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[OUT_BITS-1:MOTION_LO] == '0))
		else $error("motion reported on inactive region");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind touchpad_split_region_tracker_top tsrt_checker u_tsrt_checker (.*);

`default_nettype wire

>>> tb/touchpad_split_region_tracker_top_test.sv
// Self-checking testbench for the split-region touchpad tracker: streams reports,
// predicts the whole/left/right result items and compares them as they leave.
// Depends on tsrt_pkg and touchpad_split_region_tracker_top.
`timescale 1ns / 1ps

module touchpad_split_region_tracker_top_test;
	import tsrt_pkg::*;

	localparam int X_MAX = (1 << X_BITS) - 1;
	localparam int Y_MAX = (1 << Y_BITS) - 1;
	localparam int ID_MAX = (1 << ID_BITS) - 1;
	localparam int REPORT_BITS = $bits(report_t);
	localparam int IDLE_PCT = 32;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_REPORTS = 75;

	// One expected result item
	typedef struct packed {
		region_e region;
		logic    last;
		result_t res;
	} region_result_t;

	// Tracker state mirror and store of awaited result items
	class tracker_scoreboard;
		cfg_t cfg;
		int active[NUM_REGIONS];
		int owner[NUM_REGIONS];
		int start_x[NUM_REGIONS];
		int start_y[NUM_REGIONS];
		int abs_x[NUM_REGIONS];
		int abs_y[NUM_REGIONS];
		int disp_x[NUM_REGIONS];
		int disp_y[NUM_REGIONS];
		int inc_x[NUM_REGIONS];
		int inc_y[NUM_REGIONS];
		region_result_t awaited_results[$];
		int mismatches;
		int reports_taken;
		int results_seen;
		int writes_taken;

		function new();
			cfg.whole_ox = WHOLE_OX_RST;
			cfg.left_ox = LEFT_OX_RST;
			cfg.right_ox = RIGHT_OX_RST;
			cfg.oy = ORIGIN_Y_RST;
			cfg.split = SPLIT_RST;
			for (int r = 0; r < NUM_REGIONS; r++) begin
				active[r] = 0;
				start_x[r] = 0;
				start_y[r] = 0;
				abs_x[r] = 0;
				abs_y[r] = 0;
				disp_x[r] = 0;
				disp_y[r] = 0;
				inc_x[r] = 0;
				inc_y[r] = 0;
			end
			owner[REG_WHOLE] = ID_NONE;
			owner[REG_LEFT] = ID_NONE;
			owner[REG_RIGHT] = ID_NONE_RIGHT;
			mismatches = 0;
			reports_taken = 0;
			results_seen = 0;
			writes_taken = 0;
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			writes_taken++;
			case (idx)
				CFG_WHOLE_OX: cfg.whole_ox = data[X_BITS-1:0];
				CFG_LEFT_OX:  cfg.left_ox = data[X_BITS-1:0];
				CFG_RIGHT_OX: cfg.right_ox = data[X_BITS-1:0];
				CFG_ORIGIN_Y: cfg.oy = data[Y_BITS-1:0];
				CFG_SPLIT:    cfg.split = data[X_BITS-1:0];
				default: ;
			endcase
		endfunction

		function int x_ref(int r);
			case (region_e'(r))
				REG_WHOLE: return int'(cfg.whole_ox);
				REG_LEFT:  return int'(cfg.left_ox);
				default:   return int'(cfg.right_ox);
			endcase
		endfunction

		function int clamp(int v, int lim);
			if (v > lim) return lim;
			if (v < -lim) return -lim;
			return v;
		endfunction

		// New owner: absolute position and start point taken, no movement yet
		function void claim(int r, int id, int x, int y);
			abs_x[r] = x - x_ref(r);
			abs_y[r] = y - int'(cfg.oy);
			start_x[r] = x;
			start_y[r] = y;
			owner[r] = id;
		endfunction

		function void track(int r, int x, int y);
			int ax;
			int ay;
			ax = x - x_ref(r);
			ay = y - int'(cfg.oy);
			inc_x[r] = clamp(ax - abs_x[r], X_MAX);
			inc_y[r] = clamp(ay - abs_y[r], Y_MAX);
			abs_x[r] = ax;
			abs_y[r] = ay;
			disp_x[r] = x - start_x[r];
			disp_y[r] = y - start_y[r];
		endfunction

		// A touch owning neither half claims one by the split column
		function void route_to_half(int id, int x, int y);
			if (id != owner[REG_LEFT] && id != owner[REG_RIGHT]) begin
				if (x < int'(cfg.split)) claim(REG_LEFT, id, x, y);
				else claim(REG_RIGHT, id, x, y);
			end
			if (id == owner[REG_LEFT]) track(REG_LEFT, x, y);
			if (id == owner[REG_RIGHT]) track(REG_RIGHT, x, y);
		endfunction

		function void take_report(report_t rep);
			bit a0;
			bit a1;
			int id0;
			int id1;
			region_result_t item;
			a0 = rep.f0_absent;
			a1 = rep.f1_absent;
			id0 = int'(rep.f0_id);
			id1 = int'(rep.f1_id);
			reports_taken++;

			// both lifted: halves released
			if (a0 && a1) begin
				active[REG_LEFT] = 0;
				active[REG_RIGHT] = 0;
				owner[REG_LEFT] = ID_NONE;
				owner[REG_RIGHT] = ID_NONE_RIGHT;
			end

			// activity is settled before any claim
			active[REG_WHOLE] = !a0;
			if (owner[REG_LEFT] == id0) active[REG_LEFT] = !a0;
			if (owner[REG_RIGHT] == id0) active[REG_RIGHT] = !a0;
			if (owner[REG_LEFT] == id1) active[REG_LEFT] = !a1;
			if (owner[REG_RIGHT] == id1) active[REG_RIGHT] = !a1;

			if (!a0) begin
				if (id0 != owner[REG_WHOLE])
					claim(REG_WHOLE, id0, int'(rep.f0_x), int'(rep.f0_y));
				track(REG_WHOLE, int'(rep.f0_x), int'(rep.f0_y));
				route_to_half(id0, int'(rep.f0_x), int'(rep.f0_y));
			end
			if (!a1) route_to_half(id1, int'(rep.f1_x), int'(rep.f1_y));

			for (int r = 0; r < NUM_REGIONS; r++) begin
				if (!active[r]) begin
					disp_x[r] = 0;
					disp_y[r] = 0;
					inc_x[r] = 0;
					inc_y[r] = 0;
				end
				item.region = region_e'(r);
				item.last = (r == REG_RIGHT);
				item.res.active = active[r];
				item.res.abs_x = abs_x[r];
				item.res.abs_y = abs_y[r];
				item.res.disp_x = disp_x[r];
				item.res.disp_y = disp_y[r];
				item.res.inc_x = inc_x[r];
				item.res.inc_y = inc_y[r];
				awaited_results.push_back(item);
			end
		endfunction

		function void compare_field(string name, logic signed [31:0] want,
				logic signed [31:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch on result item %0d, %s: expected %0d, got %0d",
						results_seen, name, want, got);
			end
		endfunction

		function void check_result(logic [1:0] region, logic last, result_t got);
			region_result_t want;
			results_seen++;
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result item %0d (region %0d), nothing awaited",
						results_seen, region);
				return;
			end
			want = awaited_results.pop_front();
			compare_field("region", want.region, region);
			compare_field("last", want.last, last);
			compare_field("active", want.res.active, got.active);
			compare_field("abs_x", want.res.abs_x, got.abs_x);
			compare_field("abs_y", want.res.abs_y, got.abs_y);
			compare_field("disp_x", want.res.disp_x, got.disp_x);
			compare_field("disp_y", want.res.disp_y, got.disp_y);
			compare_field("inc_x", want.res.inc_x, got.inc_x);
			compare_field("inc_y", want.res.inc_y, got.inc_y);
		endfunction

		function void close_out();
			if (awaited_results.size() != 0) begin
				mismatches += awaited_results.size();
				$display("%0d result items never arrived", awaited_results.size());
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_BITS-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	tracker_scoreboard sb;
	bit no_idle;
	int settings_used;

	// Finger model for well-formed touch sequences
	typedef struct {
		bit                 down;
		logic [ID_BITS-1:0] id;
		int                 x;
		int                 y;
	} touch_t;
	touch_t touches[2];

	touchpad_split_region_tracker_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit idle_now();
		return !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
	endfunction

	// Receiver stalls at random
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= !idle_now();
		end
	end

	// Result items checked as they are accepted
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tlast, result_t'(m_tdata[OUT_BITS-1:0]));
	end

	// Entered and left at a falling edge
	task automatic send_report(input report_t rep);
		while (idle_now()) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_BITS'(rep);
		do @(posedge clk); while (!s_tready);
		sb.take_report(rep);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	// Only called once the block is idle; a spare index goes in with each set
	task automatic apply_settings(input int wox, input int lox, input int rox,
			input int oy, input int split);
		write_reg(CFG_IDX_BITS'($urandom_range(CFG_SPLIT + 1, (1 << CFG_IDX_BITS) - 1)),
			CFG_DATA_BITS'($urandom));
		write_reg(CFG_WHOLE_OX, wox);
		write_reg(CFG_LEFT_OX, lox);
		write_reg(CFG_RIGHT_OX, rox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_SPLIT, split);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	function automatic report_t make_report(bit a0, int id0, int x0, int y0,
			bit a1, int id1, int x1, int y1);
		report_t rep;
		rep.f0_absent = a0;
		rep.f0_id = id0;
		rep.f0_x = x0;
		rep.f0_y = y0;
		rep.f1_absent = a1;
		rep.f1_id = id1;
		rep.f1_x = x1;
		rep.f1_y = y1;
		return rep;
	endfunction

	function automatic int clip(int v, int hi);
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	// New touch: small id pool so stale owners get hit, some near the split
	function automatic void place(int k);
		int step;
		step = $urandom_range(0, 4);
		touches[k].id = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, ID_MAX);
		if (k == 1 && $urandom_range(0, 9) == 0) touches[1].id = touches[0].id;
		if ($urandom_range(0, 3) == 0) touches[k].x = clip(int'(sb.cfg.split) + step - 2, X_MAX);
		else touches[k].x = $urandom_range(0, X_MAX);
		touches[k].y = $urandom_range(0, Y_MAX);
	endfunction

	function automatic report_t next_report();
		report_t rep;
		logic [63:0] raw;
		int roll;
		int dx;
		int dy;
		raw = {$urandom, $urandom};
		rep = raw[REPORT_BITS-1:0];
		// noise: a fully random report
		if ($urandom_range(0, 99) < 10) return rep;
		for (int k = 0; k < 2; k++) begin
			roll = $urandom_range(0, 99);
			dx = $urandom_range(0, 64);
			dy = $urandom_range(0, 32);
			if (touches[k].down) begin
				if (roll < 8) touches[k].down = 1'b0;
				else if (roll < 12) place(k);
				else if (roll < 16) begin
					touches[k].x = $urandom_range(0, X_MAX);
					touches[k].y = $urandom_range(0, Y_MAX);
				end else begin
					touches[k].x = clip(touches[k].x + dx - 32, X_MAX);
					touches[k].y = clip(touches[k].y + dy - 16, Y_MAX);
				end
			end else if (roll < 35) begin
				touches[k].down = 1'b1;
				place(k);
			end
		end
		// lifted fingers keep random content in their fields
		rep.f0_absent = !touches[0].down;
		if (touches[0].down) begin
			rep.f0_id = touches[0].id;
			rep.f0_x = touches[0].x;
			rep.f0_y = touches[0].y;
		end
		rep.f1_absent = !touches[1].down;
		if (touches[1].down) begin
			rep.f1_id = touches[1].id;
			rep.f1_x = touches[1].x;
			rep.f1_y = touches[1].y;
		end
		return rep;
	endfunction

	function automatic int pick(bit extreme, int hi);
		if (extreme) return $urandom_range(0, 1) ? hi : 0;
		return $urandom_range(0, hi);
	endfunction

	// Overall run limit
	initial begin
		#2_000_000;
		$display("Timeout with %0d result items still awaited", sb.pending());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Stimulus
	initial begin
		sb = new();
		no_idle = 1'b0;
		settings_used = 1;
		touches[0].down = 1'b0;
		touches[1].down = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default settings: claims, split edges, shared ids, lift and return
		send_report(make_report(1, ID_MAX, X_MAX, Y_MAX, 1, ID_MAX, X_MAX, Y_MAX));
		send_report(make_report(0, 0, 0, 0, 1, 0, 0, 0));
		send_report(make_report(0, 0, 5, 7, 1, 0, 0, 0));
		send_report(make_report(0, 0, 959, 20, 0, ID_MAX, 960, Y_MAX));
		send_report(make_report(0, 0, 900, 30, 0, ID_MAX, X_MAX, 1000));
		send_report(make_report(0, ID_MAX, 1000, 500, 0, ID_MAX, 1010, 510));
		send_report(make_report(1, 0, 0, 0, 0, ID_MAX, 1020, 520));
		send_report(make_report(0, 55, 100, 100, 0, ID_MAX, 1030, 530));
		send_report(make_report(0, 55, 120, 110, 1, ID_MAX, 0, 0));
		send_report(make_report(0, 55, 130, 120, 0, ID_MAX, 1040, 540));
		send_report(make_report(1, 0, 0, 0, 1, 0, 0, 0));
		send_report(make_report(0, ID_MAX, X_MAX, Y_MAX, 0, 0, 0, 0));
		send_report(make_report(0, ID_MAX, 2040, 1020, 0, 0, 3, 4));
		send_report(make_report(0, 1, X_MAX, 0, 0, 2, 0, Y_MAX));

		// references at maximum, then at zero, then back: increments saturate
		drain();
		apply_settings(X_MAX, X_MAX, X_MAX, Y_MAX, 1024);
		send_report(make_report(1, 0, 0, 0, 1, 0, 0, 0));
		send_report(make_report(0, 3, 0, 0, 0, 9, X_MAX, Y_MAX));
		send_report(make_report(0, 3, 0, 0, 0, 9, X_MAX, Y_MAX));
		drain();
		// y reference written with only the bit above its width set
		apply_settings(0, 0, 0, 1 << Y_BITS, X_MAX);
		send_report(make_report(0, 3, X_MAX, Y_MAX, 0, 9, 0, 0));
		drain();
		apply_settings(X_MAX, X_MAX, X_MAX, Y_MAX, 0);
		send_report(make_report(0, 3, 0, 0, 0, 9, X_MAX, Y_MAX));
		send_report(make_report(0, 3, 0, 0, 1, 9, 0, 0));
		send_report(make_report(0, 77, 0, 0, 1, 0, 0, 0));
		send_report(make_report(1, 0, 0, 0, 1, 0, 0, 0));

		// random touch sequences, new settings per phase
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			if (p == 0)
				apply_settings(WHOLE_OX_RST, LEFT_OX_RST, RIGHT_OX_RST, ORIGIN_Y_RST,
					SPLIT_RST);
			else
				apply_settings(pick(p == 1, X_MAX), pick(p == 1, X_MAX),
					pick(p == 1, X_MAX), pick(p == 1, (1 << CFG_DATA_BITS) - 1),
					pick(p == 1, X_MAX));
			no_idle = (p == 3);
			repeat (PHASE_REPORTS) send_report(next_report());
		end
		no_idle = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		sb.close_out();
		$display("Covered %0d reports and %0d result items under %0d settings (%0d writes);",
			sb.reports_taken, sb.results_seen, settings_used, sb.writes_taken);
		$display("%0d mismatches counted", sb.mismatches);
		if (sb.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
rtl/tsrt_pkg.sv
rtl/tsrt_cfg.sv
rtl/tsrt_update.sv
rtl/touchpad_split_region_tracker_top.sv
rtl/tsrt_checker.sv
tb/touchpad_split_region_tracker_top_test.sv
